/* hw/rtl/fasp_pkg.sv */
// ----------------------------------------------------------------------------
// fasp_pkg
// Shared widths, command codes and control bundles of the step pulse generator.
// ----------------------------------------------------------------------------
package fasp_pkg;

	localparam int CHANNELS    = 4;
	localparam int TICK_HZ     = 1000000;
	localparam int MOVE_FIELDS = 4;
	localparam int OUT_LINES   = 4;

	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int MOVE_W = 32;
	localparam int CNT_W  = 31;
	localparam int RATE_W = 19;
	localparam int HALF_W = 19;
	localparam int PROD_W = RATE_W + CNT_W;
	localparam int DIV_CNT_W = $clog2(PROD_W);

	localparam logic [HALF_W-1:0] HALF_MAX = {HALF_W{1'b1}};
	localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

	localparam logic [RATE_W-1:0] MIN_RATE_RST = RATE_W'(100);
	localparam logic [RATE_W-1:0] MAX_RATE_RST = RATE_W'(10000);

	// command codes
	localparam logic [1:0] CMD_TICK     = 2'd0;
	localparam logic [1:0] CMD_START    = 2'd1;
	localparam logic [1:0] CMD_STOP_ONE = 2'd2;
	localparam logic [1:0] CMD_STOP_ALL = 2'd3;

	// configuration register indexes
	localparam logic [0:0] REG_MIN_RATE = 1'b0;
	localparam logic [0:0] REG_MAX_RATE = 1'b1;

	typedef struct packed {
		logic                tick;
		logic [CHANNELS-1:0] stop_mask;
		logic [CHANNELS-1:0] load_mask;
		logic                load_heading;
		logic [CNT_W-1:0]    load_goal;
		logic [HALF_W-1:0]   load_half;
	} bank_ctrl_t;

	typedef struct packed {
		logic [CHANNELS-1:0] level;
		logic [CHANNELS-1:0] heading;
		logic [CHANNELS-1:0] active;
	} bank_stat_t;

endpackage

/* hw/rtl/fasp_div.sv */
// ----------------------------------------------------------------------------
// fasp_div
// Restoring divider, one quotient bit per cycle, shared by the rate and
// half period computations.
// ----------------------------------------------------------------------------
module fasp_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [fasp_pkg::PROD_W-1:0] dividend,
	input  logic [fasp_pkg::CNT_W-1:0]  divisor,
	output logic                        busy,
	output logic [fasp_pkg::PROD_W-1:0] quotient
);

	logic                           busy_q;
	logic [fasp_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [fasp_pkg::PROD_W-1:0]    dvd_q;
	logic [fasp_pkg::CNT_W-1:0]     rem_q;
	logic [fasp_pkg::CNT_W-1:0]     dvs_q;

	logic [fasp_pkg::CNT_W:0]       shifted;
	logic [fasp_pkg::CNT_W+1:0]     diff;
	logic                           fits;

	assign shifted = {rem_q, dvd_q[fasp_pkg::PROD_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign fits    = !diff[fasp_pkg::CNT_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= fasp_pkg::DIV_CNT_W'(fasp_pkg::PROD_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	// quotient bits shift in where the dividend bits leave
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[fasp_pkg::PROD_W-2:0], fits};
			rem_q <= fits ? diff[fasp_pkg::CNT_W-1:0] : shifted[fasp_pkg::CNT_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = dvd_q;

endmodule

/* hw/rtl/fasp_chan_bank.sv */
// ----------------------------------------------------------------------------
// fasp_chan_bank
// Per channel step timers, pulse counters and step/direction state.
// ----------------------------------------------------------------------------
module fasp_chan_bank (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fasp_pkg::bank_ctrl_t ctrl,
	output fasp_pkg::bank_stat_t stat
);

	logic [fasp_pkg::CHANNELS-1:0] level_q;
	logic [fasp_pkg::CHANNELS-1:0] active_q;
	logic [fasp_pkg::CHANNELS-1:0] heading_q;
	logic [fasp_pkg::CNT_W-1:0]    goal_q [fasp_pkg::CHANNELS];
	logic [fasp_pkg::CNT_W-1:0]    done_q [fasp_pkg::CHANNELS];
	logic [fasp_pkg::HALF_W-1:0]   half_q [fasp_pkg::CHANNELS];
	logic [fasp_pkg::HALF_W-1:0]   tcnt_q [fasp_pkg::CHANNELS];

	for (genvar c = 0; c < fasp_pkg::CHANNELS; c++) begin : g_chan
		logic [fasp_pkg::CNT_W-1:0] done_inc;

		assign done_inc = done_q[c] + 1'b1;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				level_q[c]   <= 1'b0;
				active_q[c]  <= 1'b0;
				heading_q[c] <= 1'b0;
				goal_q[c]    <= '0;
				done_q[c]    <= '0;
				half_q[c]    <= '0;
				tcnt_q[c]    <= '0;
			end else if (ctrl.load_mask[c]) begin
				level_q[c]   <= 1'b0;
				active_q[c]  <= 1'b1;
				heading_q[c] <= ctrl.load_heading;
				goal_q[c]    <= ctrl.load_goal;
				done_q[c]    <= '0;
				half_q[c]    <= ctrl.load_half;
				tcnt_q[c]    <= '0;
			end else if (ctrl.stop_mask[c]) begin
				level_q[c]  <= 1'b0;
				active_q[c] <= 1'b0;
			end else if (ctrl.tick && active_q[c]) begin
				if (tcnt_q[c] >= half_q[c]) begin
					tcnt_q[c] <= '0;
					if (!level_q[c]) begin
						// rising edge counts one pulse
						done_q[c] <= done_inc;
						if (done_inc >= goal_q[c]) begin
							level_q[c]  <= 1'b0;
							active_q[c] <= 1'b0;
						end else begin
							level_q[c] <= 1'b1;
						end
					end else begin
						level_q[c] <= 1'b0;
					end
				end else begin
					tcnt_q[c] <= tcnt_q[c] + 1'b1;
				end
			end
		end
	end

	assign stat.level   = level_q;
	assign stat.heading = heading_q;
	assign stat.active  = active_q;

endmodule

/* hw/rtl/four_axis_step_pulse_generator.sv */
// ----------------------------------------------------------------------------
// four_axis_step_pulse_generator
// Four channel step/direction generator with a shared divider for rate setup.
//
//   channel   handshake            carries
//   in        in_valid/in_ready    cmd, move0..move3, base_rate, channel
//   out       out_valid/out_ready  step_lines, dir_lines, busy_mask, any_busy,
//                                  status
//   cfg       cfg_write            cfg_index, cfg_data (min_rate, max_rate)
//
// Tick, stop or refused start: acceptance sets emit_q, then the output register takes the result.
// Start: the moves are scanned, then each moving channel runs the shared divider twice, for its
// rate and its half period, and is loaded; a start with no moves skips the divider.
// One request is in flight at a time; in_ready is low until its result is registered.
// A stalled output holds its result; the next result waits and keeps in_ready low.
// Reset clears every channel and loads the default rate limits.
// ----------------------------------------------------------------------------
module four_axis_step_pulse_generator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [0:0]                          cfg_index,
	input  logic [fasp_pkg::RATE_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          cmd,
	input  logic signed [fasp_pkg::MOVE_W-1:0]  move0,
	input  logic signed [fasp_pkg::MOVE_W-1:0]  move1,
	input  logic signed [fasp_pkg::MOVE_W-1:0]  move2,
	input  logic signed [fasp_pkg::MOVE_W-1:0]  move3,
	input  logic [fasp_pkg::RATE_W-1:0]         base_rate,
	input  logic [1:0]                          channel,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [fasp_pkg::OUT_LINES-1:0]      step_lines,
	output logic [fasp_pkg::OUT_LINES-1:0]      dir_lines,
	output logic [fasp_pkg::OUT_LINES-1:0]      busy_mask,
	output logic                                any_busy,
	output logic                                status
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_SCAN  = 8'b0000_0010,
		ST_PICK  = 8'b0000_0100,
		ST_MUL   = 8'b0000_1000,
		ST_DIV1  = 8'b0001_0000,
		ST_CLAMP = 8'b0010_0000,
		ST_DIV2  = 8'b0100_0000,
		ST_LOAD  = 8'b1000_0000
	} seq_state_t;

	seq_state_t                    state_q;
	logic                          emit_q;
	logic [fasp_pkg::RATE_W-1:0]   min_rate_q;
	logic [fasp_pkg::RATE_W-1:0]   max_rate_q;
	logic [fasp_pkg::CH_W-1:0]     ch_q;
	logic [fasp_pkg::CNT_W-1:0]    mag_q [fasp_pkg::CHANNELS];
	logic [fasp_pkg::CHANNELS-1:0] neg_q;
	logic [fasp_pkg::CNT_W-1:0]    biggest_q;
	logic [fasp_pkg::RATE_W-1:0]   base_q;
	logic [fasp_pkg::PROD_W-1:0]   prod_q;
	logic [fasp_pkg::RATE_W-1:0]   rate_q;
	logic                          status_q;

	logic                          out_valid_q;
	logic [fasp_pkg::OUT_LINES-1:0] step_q, dir_q, busy_q;
	logic                          any_q, stat_out_q;

	logic                          accept;
	logic                          last_ch;
	logic signed [fasp_pkg::MOVE_W-1:0] move_arr [fasp_pkg::MOVE_FIELDS];
	logic [fasp_pkg::CNT_W-1:0]    mag_in [fasp_pkg::CHANNELS];
	logic [fasp_pkg::CHANNELS-1:0] neg_in;
	logic [fasp_pkg::RATE_W-1:0]   rate_clamped;
	logic [fasp_pkg::RATE_W:0]     toggle;
	logic [fasp_pkg::HALF_W-1:0]   half_val;
	logic                          any_active;
	logic                          out_free;

	fasp_pkg::bank_ctrl_t          bank_ctrl;
	fasp_pkg::bank_stat_t          bank_stat;

	logic                          div_start;
	logic [fasp_pkg::PROD_W-1:0]   div_dividend;
	logic [fasp_pkg::CNT_W-1:0]    div_divisor;
	logic                          div_busy;
	logic [fasp_pkg::PROD_W-1:0]   div_quot;

	assign move_arr[0] = move0;
	assign move_arr[1] = move1;
	assign move_arr[2] = move2;
	assign move_arr[3] = move3;

	assign in_ready   = (state_q == ST_IDLE) && !emit_q;
	assign accept     = in_valid && in_ready;
	assign last_ch    = (ch_q == fasp_pkg::CH_W'(fasp_pkg::CHANNELS - 1));
	assign any_active = |bank_stat.active;
	assign out_free   = !out_valid_q || out_ready;

	// magnitude and sign of each move, saturated to the count width
	always_comb begin
		logic [fasp_pkg::MOVE_W-1:0] raw;
		logic [fasp_pkg::MOVE_W-1:0] mag;
		for (int c = 0; c < fasp_pkg::CHANNELS; c++) begin
			raw = '0;
			if (c < fasp_pkg::MOVE_FIELDS) begin
				raw = move_arr[c];
			end
			neg_in[c] = raw[fasp_pkg::MOVE_W-1];
			mag = neg_in[c] ? (fasp_pkg::MOVE_W'(0) - raw) : raw;
			mag_in[c] = mag[fasp_pkg::MOVE_W-1] ? fasp_pkg::CNT_MAX : mag[fasp_pkg::CNT_W-1:0];
		end
	end

	// clamp to the configured window, a zero rate falls back to min_rate, then to one
	always_comb begin
		rate_clamped = rate_q;
		if (rate_clamped < min_rate_q) begin
			rate_clamped = min_rate_q;
		end
		if (rate_clamped > max_rate_q) begin
			rate_clamped = max_rate_q;
		end
		if (rate_clamped == '0) begin
			rate_clamped = min_rate_q;
		end
		if (rate_clamped == '0) begin
			rate_clamped = fasp_pkg::RATE_W'(1);
		end
		toggle = {rate_clamped, 1'b0};
	end

	// half period = quotient - 1, floored at zero and saturated
	always_comb begin
		if (div_quot == '0) begin
			half_val = '0;
		end else if (div_quot > fasp_pkg::PROD_W'(fasp_pkg::HALF_MAX) + 1'b1) begin
			half_val = fasp_pkg::HALF_MAX;
		end else begin
			half_val = fasp_pkg::HALF_W'(div_quot - 1'b1);
		end
	end

	assign div_start    = (state_q == ST_MUL) || (state_q == ST_CLAMP);
	assign div_dividend = (state_q == ST_MUL) ? prod_q : fasp_pkg::PROD_W'(fasp_pkg::TICK_HZ);
	assign div_divisor  = (state_q == ST_MUL) ? biggest_q : fasp_pkg::CNT_W'(toggle);

	always_comb begin
		bank_ctrl = '0;
		bank_ctrl.tick = accept && (cmd == fasp_pkg::CMD_TICK);
		for (int c = 0; c < fasp_pkg::CHANNELS; c++) begin
			if (accept && (cmd == fasp_pkg::CMD_STOP_ALL)) begin
				bank_ctrl.stop_mask[c] = 1'b1;
			end else if (accept && (cmd == fasp_pkg::CMD_STOP_ONE)) begin
				bank_ctrl.stop_mask[c] = (32'(channel) == c);
			end
			bank_ctrl.load_mask[c] = (state_q == ST_LOAD) && (ch_q == fasp_pkg::CH_W'(c));
		end
		bank_ctrl.load_heading = !neg_q[ch_q];
		bank_ctrl.load_goal    = mag_q[ch_q];
		bank_ctrl.load_half    = half_val;
	end

	fasp_chan_bank u_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (bank_ctrl),
		.stat   (bank_stat)
	);

	fasp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_rate_q <= fasp_pkg::MIN_RATE_RST;
			max_rate_q <= fasp_pkg::MAX_RATE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				fasp_pkg::REG_MIN_RATE: min_rate_q <= cfg_data;
				fasp_pkg::REG_MAX_RATE: max_rate_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			emit_q  <= 1'b0;
			ch_q    <= '0;
		end else begin
			if (emit_q && out_free) begin
				emit_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ch_q <= '0;
						if ((cmd == fasp_pkg::CMD_START) && !any_active) begin
							state_q <= ST_SCAN;
						end else begin
							emit_q <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (last_ch) begin
						ch_q    <= '0;
						state_q <= ST_PICK;
					end else begin
						ch_q <= ch_q + 1'b1;
					end
				end
				ST_PICK: begin
					if (biggest_q == '0) begin
						emit_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (mag_q[ch_q] != '0) begin
						state_q <= ST_MUL;
					end else if (last_ch) begin
						emit_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						ch_q <= ch_q + 1'b1;
					end
				end
				ST_MUL: state_q <= ST_DIV1;
				ST_DIV1: begin
					if (!div_busy) begin
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: state_q <= ST_DIV2;
				ST_DIV2: begin
					if (!div_busy) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (last_ch) begin
						emit_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						ch_q    <= ch_q + 1'b1;
						state_q <= ST_PICK;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working registers of a start
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q  <= (cmd == fasp_pkg::CMD_START) && any_active;
			biggest_q <= '0;
			base_q    <= base_rate;
			neg_q     <= neg_in;
			for (int c = 0; c < fasp_pkg::CHANNELS; c++) begin
				mag_q[c] <= mag_in[c];
			end
		end
		if ((state_q == ST_SCAN) && (mag_q[ch_q] > biggest_q)) begin
			biggest_q <= mag_q[ch_q];
		end
		if (state_q == ST_PICK) begin
			prod_q <= base_q * mag_q[ch_q];
		end
		if ((state_q == ST_DIV1) && !div_busy) begin
			rate_q <= div_quot[fasp_pkg::RATE_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_q && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_q && out_free) begin
			for (int i = 0; i < fasp_pkg::OUT_LINES; i++) begin
				if (i < fasp_pkg::CHANNELS) begin
					step_q[i] <= bank_stat.level[i];
					dir_q[i]  <= bank_stat.heading[i];
					busy_q[i] <= bank_stat.active[i];
				end else begin
					step_q[i] <= 1'b0;
					dir_q[i]  <= 1'b0;
					busy_q[i] <= 1'b0;
				end
			end
			any_q      <= any_active;
			stat_out_q <= status_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign step_lines = step_q;
	assign dir_lines  = dir_q;
	assign busy_mask  = busy_q;
	assign any_busy   = any_q;
	assign status     = stat_out_q;

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Request/result checker for the four channel step pulse generator. Ticks,
// starts and stops go in through the request channel with random gaps, the
// result channel stalls at random, and every result is compared against a
// cycle-free model of the channel counters. Rate limits are changed between
// phases, including both range extremes and a minimum above the maximum.
// ----------------------------------------------------------------------------
module tb;
	import fasp_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int PHASE_ITEMS   = 40;
	localparam int SETTLE_CYCLES = 32;

	typedef struct packed {
		logic [1:0]                              op;
		logic [MOVE_FIELDS-1:0][MOVE_W-1:0]      moves;
		logic [RATE_W-1:0]                       base;
		logic [1:0]                              chan;
	} request_t;

	typedef struct packed {
		logic [OUT_LINES-1:0] step;
		logic [OUT_LINES-1:0] dir;
		logic [OUT_LINES-1:0] busy;
		logic                 any;
		logic                 refused;
	} lines_t;

	// predicts channel state per request and holds the results still owed
	class step_scoreboard;
		bit [RATE_W-1:0] min_rate;
		bit [RATE_W-1:0] max_rate;
		bit              level_q [CHANNELS];
		bit              running_q [CHANNELS];
		bit              forward_q [CHANNELS];
		bit [CNT_W-1:0]  goal_q [CHANNELS];
		bit [CNT_W-1:0]  made_q [CHANNELS];
		bit [HALF_W-1:0] half_q [CHANNELS];
		bit [HALF_W-1:0] ticks_q [CHANNELS];
		lines_t          owed [$];
		int              mismatches;
		int              checked;
		int              starts_taken;
		int              starts_refused;
		int              pulses;

		function new();
			min_rate = MIN_RATE_RST;
			max_rate = MAX_RATE_RST;
			for (int c = 0; c < CHANNELS; c++) begin
				level_q[c] = 0;
				running_q[c] = 0;
				forward_q[c] = 0;
				goal_q[c] = 0;
				made_q[c] = 0;
				half_q[c] = 0;
				ticks_q[c] = 0;
			end
		endfunction

		function void set_reg(logic [0:0] idx, logic [RATE_W-1:0] value);
			if (idx == REG_MIN_RATE) min_rate = value;
			else max_rate = value;
		endfunction

		function bit running();
			for (int c = 0; c < CHANNELS; c++)
				if (running_q[c]) return 1'b1;
			return 1'b0;
		endfunction

		function int pending();
			return owed.size();
		endfunction

		function bit [HALF_W-1:0] half_for_rate(bit [31:0] rate);
			bit [63:0] toggle;
			bit [63:0] q;
			if (rate < min_rate) rate = min_rate;
			if (rate > max_rate) rate = max_rate;
			toggle = 64'(rate) * 2;
			if (toggle == 0) toggle = 64'(min_rate) * 2;
			if (toggle == 0) toggle = 2;
			q = 64'(TICK_HZ) / toggle;
			if (q == 0) return '0;
			q = q - 1;
			if (q > 64'(HALF_MAX)) q = 64'(HALF_MAX);
			return q[HALF_W-1:0];
		endfunction

		function void note_request(request_t rq);
			lines_t    want;
			bit [31:0] raw;
			bit [31:0] mag [CHANNELS];
			bit        neg [CHANNELS];
			bit [31:0] biggest;
			bit [63:0] prod;
			bit [31:0] rate;
			want = '0;
			biggest = 0;
			case (rq.op)
				CMD_TICK: begin
					for (int c = 0; c < CHANNELS; c++) begin
						if (!running_q[c]) continue;
						if (ticks_q[c] >= half_q[c]) begin
							ticks_q[c] = 0;
							level_q[c] = ~level_q[c];
							if (level_q[c]) begin
								made_q[c] = made_q[c] + 1'b1;
								pulses++;
								if (made_q[c] >= goal_q[c]) begin
									level_q[c] = 0;
									running_q[c] = 0;
								end
							end
						end else begin
							ticks_q[c] = ticks_q[c] + 1'b1;
						end
					end
				end
				CMD_START: begin
					if (running()) begin
						want.refused = 1'b1;
						starts_refused++;
					end else begin
						for (int c = 0; c < CHANNELS; c++) begin
							raw = (c < MOVE_FIELDS) ? rq.moves[c] : 32'd0;
							neg[c] = raw[31];
							mag[c] = neg[c] ? 32'd0 - raw : raw;
							if (mag[c] > 32'(CNT_MAX)) mag[c] = 32'(CNT_MAX);
							if (mag[c] > biggest) biggest = mag[c];
						end
						if (biggest != 0) begin
							starts_taken++;
							for (int c = 0; c < CHANNELS; c++) begin
								if (mag[c] == 0) continue;
								// wide product so the scaled rate never wraps
								prod = 64'(rq.base) * 64'(mag[c]);
								rate = 32'(prod / 64'(biggest));
								if (rate < min_rate) rate = min_rate;
								forward_q[c] = ~neg[c];
								level_q[c] = 0;
								made_q[c] = 0;
								goal_q[c] = mag[c][CNT_W-1:0];
								running_q[c] = 1;
								ticks_q[c] = 0;
								half_q[c] = half_for_rate(rate);
							end
						end
					end
				end
				CMD_STOP_ONE: begin
					if (int'(rq.chan) < CHANNELS) begin
						level_q[rq.chan] = 0;
						running_q[rq.chan] = 0;
					end
				end
				default: begin
					for (int c = 0; c < CHANNELS; c++) begin
						level_q[c] = 0;
						running_q[c] = 0;
					end
				end
			endcase
			for (int c = 0; c < CHANNELS && c < OUT_LINES; c++) begin
				want.step[c] = level_q[c];
				want.dir[c] = forward_q[c];
				want.busy[c] = running_q[c];
			end
			want.any = running();
			owed.push_back(want);
		endfunction

		function void check_result(lines_t got);
			lines_t want;
			bit     bad;
			checked++;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with no request owed: step=%h dir=%h busy=%h any=%b st=%b",
						$realtime, got.step, got.dir, got.busy, got.any, got.refused);
				return;
			end
			want = owed.pop_front();
			bad = (got.step !== want.step) || (got.dir !== want.dir) ||
				(got.busy !== want.busy) || (got.any !== want.any) ||
				(got.refused !== want.refused);
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: result %0d wrong", $realtime, checked);
					$display("  expected step=%h dir=%h busy=%h any=%b st=%b",
						want.step, want.dir, want.busy, want.any, want.refused);
					$display("  actual   step=%h dir=%h busy=%h any=%b st=%b",
						got.step, got.dir, got.busy, got.any, got.refused);
				end
			end
		endfunction
	endclass

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_write = 1'b0;
	logic [0:0]                       cfg_index = '0;
	logic [RATE_W-1:0]                cfg_data = '0;
	logic                             in_valid = 1'b0;
	logic                             in_ready;
	logic [1:0]                       cmd = CMD_TICK;
	logic signed [MOVE_W-1:0]         move0 = '0;
	logic signed [MOVE_W-1:0]         move1 = '0;
	logic signed [MOVE_W-1:0]         move2 = '0;
	logic signed [MOVE_W-1:0]         move3 = '0;
	logic [RATE_W-1:0]                base_rate = '0;
	logic [1:0]                       channel = '0;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	logic [OUT_LINES-1:0]             step_lines;
	logic [OUT_LINES-1:0]             dir_lines;
	logic [OUT_LINES-1:0]             busy_mask;
	logic                             any_busy;
	logic                             status;

	step_scoreboard sb = new();
	bit             quiet = 1'b0;
	int             stall_left = 0;
	int             cycles = 0;
	int             requests_sent = 0;
	int             settings_used = 1;

	four_axis_step_pulse_generator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .move0(move0), .move1(move1), .move2(move2), .move3(move3),
		.base_rate(base_rate), .channel(channel),
		.out_valid(out_valid), .out_ready(out_ready),
		.step_lines(step_lines), .dir_lines(dir_lines), .busy_mask(busy_mask),
		.any_busy(any_busy), .status(status)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycles, sb.pending());
			$display("Mismatches found");
			$finish;
		end
	end

	// result side back-pressure in bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (quiet) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 7) == 0) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(0, 8);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{step_lines, dir_lines, busy_mask, any_busy, status});
	end

	// every field random, so ignored fields still toggle all their bits
	function automatic request_t noise_request();
		request_t rq;
		rq.op = 2'($urandom_range(0, 3));
		for (int i = 0; i < MOVE_FIELDS; i++) rq.moves[i] = $urandom;
		rq.base = RATE_W'($urandom_range(0, 500000));
		rq.chan = 2'($urandom_range(0, 3));
		return rq;
	endfunction

	function automatic request_t plain_request(logic [1:0] op);
		request_t rq;
		rq = noise_request();
		rq.op = op;
		return rq;
	endfunction

	function automatic request_t start_request(int m0, int m1, int m2, int m3,
		int unsigned rate);
		request_t rq;
		rq = noise_request();
		rq.op = CMD_START;
		rq.moves[0] = m0;
		rq.moves[1] = m1;
		rq.moves[2] = m2;
		rq.moves[3] = m3;
		rq.base = RATE_W'(rate);
		return rq;
	endfunction

	function automatic int short_move();
		int mag;
		if ($urandom_range(0, 3) == 0) return 0;
		mag = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 4);
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	function automatic request_t short_start();
		int unsigned rate;
		rate = ($urandom_range(0, 9) < 7) ? $urandom_range(250000, 500000)
			: $urandom_range(0, 500000);
		return start_request(short_move(), short_move(), short_move(), short_move(), rate);
	endfunction

	task automatic send_request(request_t rq);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= rq.op;
		move0 <= rq.moves[0];
		move1 <= rq.moves[1];
		move2 <= rq.moves[2];
		move3 <= rq.moves[3];
		base_rate <= rq.base;
		channel <= rq.chan;
		do @(posedge clk); while (!in_ready);
		sb.note_request(rq);
		requests_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limits(int unsigned lo, int unsigned hi);
		cfg_write <= 1'b1;
		cfg_index <= REG_MIN_RATE;
		cfg_data <= RATE_W'(lo);
		@(posedge clk);
		sb.set_reg(REG_MIN_RATE, RATE_W'(lo));
		cfg_index <= REG_MAX_RATE;
		cfg_data <= RATE_W'(hi);
		@(posedge clk);
		sb.set_reg(REG_MAX_RATE, RATE_W'(hi));
		cfg_write <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	// a start followed by a run of ticks, with the odd stop or early start
	task automatic move_sequence();
		int n;
		int pick;
		if (sb.running() && $urandom_range(0, 4) != 0)
			send_request(plain_request(CMD_STOP_ALL));
		send_request(short_start());
		n = $urandom_range(4, 40);
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 85) send_request(plain_request(CMD_TICK));
			else if (pick < 92) send_request(plain_request(CMD_STOP_ONE));
			else if (pick < 97) send_request(short_start());
			else send_request(plain_request(CMD_STOP_ALL));
		end
	endtask

	int unsigned min_tab [6] = '{1, 250000, 500000, 300000, 1, 100};
	int unsigned max_tab [6] = '{500000, 500000, 500000, 1000, 1, 10000};
	int          phase_end;

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset rate limits
		send_request(plain_request(CMD_TICK));
		send_request(plain_request(CMD_STOP_ALL));
		begin
			request_t rq;
			rq = plain_request(CMD_STOP_ONE);
			rq.chan = 2'd3;
			send_request(rq);
		end
		send_request(start_request(0, 0, 0, 0, 500000));
		// most negative count saturates and becomes the longest axis
		send_request(start_request(3, -2, 0, 32'h8000_0000, 500000));
		send_request(start_request(1, 1, 1, 1, 500000));
		send_request(plain_request(CMD_TICK));
		send_request(plain_request(CMD_TICK));
		begin
			request_t rq;
			rq = plain_request(CMD_STOP_ONE);
			rq.chan = 2'd3;
			send_request(rq);
			rq.chan = 2'd0;
			send_request(rq);
		end
		send_request(plain_request(CMD_STOP_ALL));
		send_request(start_request(32'h7FFF_FFFF, -32'sd2147483647, 5, 0, 0));
		send_request(plain_request(CMD_TICK));
		send_request(plain_request(CMD_STOP_ALL));
		// idle channels keep their previous direction
		send_request(start_request(0, 0, 0, 7, 500000));
		send_request(plain_request(CMD_TICK));
		send_request(plain_request(CMD_STOP_ALL));
		send_request(start_request(1, -1, 2, -2, 1));
		repeat (4) send_request(plain_request(CMD_TICK));
		send_request(plain_request(CMD_STOP_ALL));

		for (int ph = 0; ph <= 6; ph++) begin
			if (ph > 0) begin
				drain();
				write_limits(min_tab[ph-1], max_tab[ph-1]);
			end
			quiet = (ph == 6);
			phase_end = requests_sent + PHASE_ITEMS;
			while (requests_sent < phase_end) begin
				if ($urandom_range(0, 9) < 8) move_sequence();
				else send_request(noise_request());
			end
		end
		drain();

		if (sb.pending() != 0) sb.mismatches += sb.pending();
		$display("%0d requests over %0d rate settings: %0d starts taken, %0d refused",
			requests_sent, settings_used, sb.starts_taken, sb.starts_refused);
		$display("%0d results checked, %0d step pulses predicted, %0d mismatches",
			sb.checked, sb.pulses, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
